### sv/slt_pkg.sv
// Package for the sorted list table: beat payload types, operation and status codes,
// and the command and flag structs that join the controller and the datapath.
// It has no dependencies.
`default_nettype none

package slt_pkg;

    localparam int KIND_W = 2;
    localparam int VALUE_W = 32;
    localparam int STATUS_W = 2;
    localparam int ENTRY_COUNT_W = 5;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } rsp_t;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_TOP,
        IDX_ZERO,
        IDX_STEP
    } idx_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        WADDR_UP,
        WADDR_DOWN,
        WADDR_ZERO
    } waddr_sel_t;

    typedef struct packed {
        logic                capture;
        idx_op_t             idx_op;
        logic                idx_down;
        logic                wr_en;
        waddr_sel_t          waddr_sel;
        logic                wdata_value;
        logic                set_found;
        logic                clr_found;
        cnt_op_t             cnt_op;
        logic                load_out;
        logic [STATUS_W-1:0] out_status;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              full;
        logic              empty;
        logic              hit;
        logic              ge;
        logic              first;
        logic              last;
        logic              found;
    } flags_t;

endpackage

`default_nettype wire

### sv/slt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// It has no dependencies.
`default_nettype none

module slt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### sv/slt_datapath.sv
// Datapath of the sorted list table: request and result registers, scan index,
// entry count, found flag and the entry RAM. Depends on slt_pkg and slt_ram.
`default_nettype none

module slt_datapath #(
    parameter int CAPACITY = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire slt_pkg::req_t s_req,
    input  wire slt_pkg::cmd_t cmd,
    output slt_pkg::flags_t    flags,
    output slt_pkg::rsp_t      m_rsp
);

    import slt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    req_t             req_reg;
    rsp_t             rsp_reg;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             found_reg, found_next;
    logic [CNT_W-1:0] count_less_one;
    logic [CNT_W-1:0] idx_up;
    logic [CNT_W-1:0] idx_down;
    logic [AW-1:0]    waddr;
    logic [VALUE_W-1:0] wdata;
    logic [VALUE_W-1:0] rdata;

    assign count_less_one = count_reg - CNT_W'(1);
    assign idx_up = idx_reg + CNT_W'(1);
    assign idx_down = idx_reg - CNT_W'(1);

    always_comb begin
        case (cmd.waddr_sel)
            WADDR_UP:   waddr = idx_up[AW-1:0];
            WADDR_DOWN: waddr = idx_down[AW-1:0];
            default:    waddr = '0;
        endcase
        wdata = cmd.wdata_value ? req_reg.value : rdata;
    end

    slt_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rdata)
    );

    always_comb begin
        case (cmd.idx_op)
            IDX_TOP:  idx_next = count_less_one;
            IDX_ZERO: idx_next = '0;
            IDX_STEP: idx_next = cmd.idx_down ? idx_down : idx_up;
            default:  idx_next = idx_reg;
        endcase
        case (cmd.cnt_op)
            CNT_INC: count_next = count_reg + CNT_W'(1);
            CNT_DEC: count_next = count_less_one;
            default: count_next = count_reg;
        endcase
        found_next = found_reg;
        if (cmd.clr_found) begin
            found_next = 1'b0;
        end else if (cmd.set_found) begin
            found_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            found_reg <= 1'b0;
            idx_reg <= '0;
        end else begin
            count_reg <= count_next;
            found_reg <= found_next;
            idx_reg <= idx_next;
        end
        if (cmd.capture) begin
            req_reg <= s_req;
        end
        if (cmd.load_out) begin
            rsp_reg.status <= cmd.out_status;
            rsp_reg.entry_count <= ENTRY_COUNT_W'(count_reg);
        end
    end

    always_comb begin
        flags.kind = req_reg.kind;
        flags.full = (count_reg == CNT_W'(CAPACITY));
        flags.empty = (count_reg == '0);
        flags.hit = (rdata == req_reg.value);
        flags.ge = ($signed(rdata) >= $signed(req_reg.value));
        flags.first = (idx_reg == '0);
        flags.last = (idx_reg == count_less_one);
        flags.found = found_reg;
    end

    assign m_rsp = rsp_reg;

endmodule

`default_nettype wire

### sv/slt_controller.sv
// Controller of the sorted list table: sequences the entry scan for each request
// and owns both handshakes. Depends on slt_pkg.
`default_nettype none

module slt_controller (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire logic            m_ready,
    input  wire slt_pkg::flags_t flags,
    output slt_pkg::cmd_t        cmd
);

    import slt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_CMP,
        ST_PUT,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        status_next = status_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd = '{
            capture: 1'b0, idx_op: IDX_HOLD, idx_down: 1'b0, wr_en: 1'b0,
            waddr_sel: WADDR_UP, wdata_value: 1'b0, set_found: 1'b0,
            clr_found: 1'b0, cnt_op: CNT_HOLD, load_out: 1'b0, out_status: status_reg
        };
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                case (flags.kind) inside
                    KIND_INSERT: begin
                        if (flags.full) begin
                            status_next = STATUS_FULL;
                            state_next = ST_DONE;
                        end else if (flags.empty) begin
                            cmd.wr_en = 1'b1;
                            cmd.waddr_sel = WADDR_ZERO;
                            cmd.wdata_value = 1'b1;
                            cmd.cnt_op = CNT_INC;
                            status_next = STATUS_OK;
                            state_next = ST_DONE;
                        end else begin
                            cmd.idx_op = IDX_TOP;
                            state_next = ST_READ;
                        end
                    end
                    KIND_REMOVE, KIND_LOOKUP: begin
                        if (flags.empty) begin
                            status_next = STATUS_MISSING;
                            state_next = ST_DONE;
                        end else begin
                            cmd.idx_op = IDX_ZERO;
                            cmd.clr_found = 1'b1;
                            state_next = ST_READ;
                        end
                    end
                    default: begin
                        status_next = STATUS_MISSING;
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_READ: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                case (flags.kind)
                    KIND_INSERT: begin
                        cmd.wr_en = 1'b1;
                        cmd.waddr_sel = WADDR_UP;
                        if (flags.ge) begin
                            if (flags.first) begin
                                state_next = ST_PUT;
                            end else begin
                                cmd.idx_op = IDX_STEP;
                                cmd.idx_down = 1'b1;
                                state_next = ST_READ;
                            end
                        end else begin
                            cmd.wdata_value = 1'b1;
                            cmd.cnt_op = CNT_INC;
                            status_next = STATUS_OK;
                            state_next = ST_DONE;
                        end
                    end
                    KIND_REMOVE: begin
                        if (flags.found) begin
                            cmd.wr_en = 1'b1;
                            cmd.waddr_sel = WADDR_DOWN;
                        end else if (flags.hit) begin
                            cmd.set_found = 1'b1;
                        end
                        if (flags.last) begin
                            if (flags.found || flags.hit) begin
                                cmd.cnt_op = CNT_DEC;
                                status_next = STATUS_OK;
                            end else begin
                                status_next = STATUS_MISSING;
                            end
                            state_next = ST_DONE;
                        end else begin
                            cmd.idx_op = IDX_STEP;
                            state_next = ST_READ;
                        end
                    end
                    default: begin
                        if (flags.hit) begin
                            status_next = STATUS_OK;
                            state_next = ST_DONE;
                        end else if (flags.last) begin
                            status_next = STATUS_MISSING;
                            state_next = ST_DONE;
                        end else begin
                            cmd.idx_op = IDX_STEP;
                            state_next = ST_READ;
                        end
                    end
                endcase
            end
            ST_PUT: begin
                cmd.wr_en = 1'b1;
                cmd.waddr_sel = WADDR_ZERO;
                cmd.wdata_value = 1'b1;
                cmd.cnt_op = CNT_INC;
                status_next = STATUS_OK;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            status_reg <= STATUS_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            status_reg <= status_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

### sv/sorted_list_table_unit.sv
// Top level of the sorted list table: joins the controller and the datapath.
// Depends on slt_pkg, slt_controller and slt_datapath.
//
// The unit keeps up to CAPACITY signed 32-bit entries in ascending order in a RAM and
// serves one request at a time: insert, remove or lookup, each answered by one result
// beat with a status and the entry count. A request walks the stored entries through
// the single read port of the RAM one entry at a time, first addressing the entry and
// then comparing it and writing back. An insert scans down from the top entry, a
// remove or lookup scans up from entry zero, and a lookup stops at the first match. A
// finished result waits in an output register, and the next request is taken while it
// waits.
`default_nettype none

module sorted_list_table_unit #(
    parameter int CAPACITY = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire slt_pkg::req_t s_req,
    output logic               m_valid,
    input  wire logic          m_ready,
    output slt_pkg::rsp_t      m_rsp
);

    import slt_pkg::*;

    cmd_t   cmd;
    flags_t flags;

    slt_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .flags   (flags),
        .cmd     (cmd)
    );

    slt_datapath #(
        .CAPACITY(CAPACITY)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_req   (s_req),
        .cmd     (cmd),
        .flags   (flags),
        .m_rsp   (m_rsp)
    );

endmodule

`default_nettype wire
